@@ src/servo_status_packet_receiver_macros.svh @@
// ------------------------------------------------------------------------
// servo status packet receiver assertion macros
// concurrent checks used by the receiver top level
// ------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH
`define SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH

// check that holds on every edge, reset included
`define SSPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

// implication checked outside reset
`define SSPR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the following cycle, reset included
`define SSPR_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sspr_pkg.sv @@
// ------------------------------------------------------------------------
// sspr_pkg
// types and codes for the servo status packet receiver
// ------------------------------------------------------------------------
`default_nettype none

package sspr_pkg;

    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_ID       = 3'd4,
        ST_SERVO    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HUNT  = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_ERR   = 3'd4,
        PH_PARAM = 3'd5,
        PH_CSUM  = 3'd6
    } phase_t;

    localparam logic KIND_PARAM = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
        logic [7:0] match_id;
        logic [7:0] capacity;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] param_value;
        logic [7:0] param_index;
        logic [2:0] status;
        logic [7:0] servo_error;
        logic [7:0] param_count;
        logic       last;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/sspr_parser.sv @@
// ------------------------------------------------------------------------
// sspr_parser
// byte-wise status packet state machine, one request per cycle while take is high
// ------------------------------------------------------------------------
`default_nettype none

module sspr_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire sspr_pkg::in_item_t req,
    output logic                  res_valid,
    output sspr_pkg::out_item_t   res
);
    import sspr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] prev_byte_reg, prev_byte_next;
    logic [7:0] want_id_reg, want_id_next;
    logic [7:0] cap_limit_reg, cap_limit_next;
    logic [7:0] got_id_reg, got_id_next;
    logic [7:0] got_error_reg, got_error_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] kept_err_reg, kept_err_next;

    logic [7:0] b;
    logic [7:0] len_params;

    assign b          = req.byte_value;
    assign len_params = b - LEN_OVERHEAD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            prev_byte_reg <= '0;
            want_id_reg   <= '0;
            cap_limit_reg <= '0;
            got_id_reg    <= '0;
            got_error_reg <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            kept_err_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            prev_byte_reg <= prev_byte_next;
            want_id_reg   <= want_id_next;
            cap_limit_reg <= cap_limit_next;
            got_id_reg    <= got_id_next;
            got_error_reg <= got_error_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            kept_err_reg  <= kept_err_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        prev_byte_next = prev_byte_reg;
        want_id_next   = want_id_reg;
        cap_limit_next = cap_limit_reg;
        got_id_next    = got_id_reg;
        got_error_next = got_error_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        kept_err_next  = kept_err_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.servo_error = kept_err_reg;

        if (take) begin
            unique case (req.req_type)
                REQ_START: begin
                    want_id_next   = req.match_id;
                    cap_limit_next = req.capacity;
                    prev_byte_next = '0;
                    got_id_next    = '0;
                    got_error_next = '0;
                    sum_next       = '0;
                    left_next      = '0;
                    pos_next       = '0;
                    phase_next     = PH_HUNT;
                end
                REQ_TIMEOUT: begin
                    if (phase_reg != PH_IDLE) begin
                        res_valid    = 1'b1;
                        res.out_kind = KIND_FINAL;
                        res.status   = ST_TIMEOUT;
                        res.last     = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
                REQ_BYTE: begin
                    unique case (phase_reg)
                        PH_HUNT: begin
                            if (prev_byte_reg == HDR_BYTE && b == HDR_BYTE) begin
                                phase_next = PH_ID;
                            end else begin
                                prev_byte_next = b;
                            end
                        end
                        PH_ID: begin
                            got_id_next = b;
                            sum_next    = b;
                            phase_next  = PH_LEN;
                        end
                        PH_LEN: begin
                            sum_next = sum_reg + b;
                            if (b < LEN_OVERHEAD || len_params > cap_limit_reg) begin
                                res_valid    = 1'b1;
                                res.out_kind = KIND_FINAL;
                                res.status   = ST_LENGTH;
                                res.last     = 1'b1;
                                phase_next   = PH_IDLE;
                            end else begin
                                left_next  = len_params;
                                phase_next = PH_ERR;
                            end
                        end
                        PH_ERR: begin
                            got_error_next = b;
                            sum_next       = sum_reg + b;
                            phase_next     = (left_reg != '0) ? PH_PARAM : PH_CSUM;
                        end
                        PH_PARAM: begin
                            sum_next        = sum_reg + b;
                            pos_next        = pos_reg + 8'd1;
                            left_next       = left_reg - 8'd1;
                            if (left_reg == 8'd1) begin
                                phase_next = PH_CSUM;
                            end
                            res_valid       = 1'b1;
                            res.out_kind    = KIND_PARAM;
                            res.param_value = b;
                            res.param_index = pos_reg;
                            res.servo_error = '0;
                        end
                        PH_CSUM: begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_FINAL;
                            res.last     = 1'b1;
                            phase_next   = PH_IDLE;
                            if (b != ~sum_reg) begin
                                res.status = ST_CHECKSUM;
                            end else if (got_id_reg != want_id_reg) begin
                                res.status = ST_ID;
                            end else begin
                                kept_err_next   = got_error_reg;
                                res.servo_error = got_error_reg;
                                res.param_count = pos_reg;
                                res.status      = (got_error_reg != '0) ? ST_SERVO : ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/servo_status_packet_receiver.sv @@
// ------------------------------------------------------------------------
// servo_status_packet_receiver
// status reply receiver for a half-duplex servo bus
// ------------------------------------------------------------------------
// s_ channel: one request per transfer, start (expected id and capacity),
//   received byte, or timeout
// m_ channel: parameter bytes as they arrive, then one final status with
//   last set; requests that cause no result produce nothing
// latency: a result appears on m_valid the cycle after its request is
//   taken
// throughput: one request per cycle, set by the single output register;
//   s_ready is high whenever that register is empty or being drained
// reset: the receiver goes idle, all kept values clear, m_valid drops
// stall: while m_valid is high and m_ready low, s_ready is low and the
//   pending result holds
// the receiver ignores bytes and timeouts while idle; a start during a
//   reply drops it silently
// ------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_receiver (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sspr_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sspr_pkg::out_item_t      m_data
);
    import sspr_pkg::*;

    `include "servo_status_packet_receiver_macros.svh"

    logic      take;
    logic      res_valid;
    out_item_t res;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    sspr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .req       (s_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_ready) begin
            m_valid_next = res_valid;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SSPR_ASSERT_NEXT(a_reset_clears, aclk, !aresetn, !m_valid, "result valid after reset")
    `SSPR_ASSERT_IMPL(a_last_is_final, aclk, aresetn, m_valid, m_data.last == m_data.out_kind, "last and kind disagree")
    `SSPR_ASSERT_IMPL(a_count_only_ok, aclk, aresetn, m_valid && m_data.param_count != 8'd0, m_data.status == ST_OK || m_data.status == ST_SERVO, "count on failed reply")
    `SSPR_ASSERT_ALWAYS(a_no_take_stalled, aclk, !aresetn || !(m_valid && !m_ready && s_ready), "taken while stalled")

endmodule

`default_nettype wire
